// ===== hw/rtl/srw_pkg.sv =====
// Package for the sequence reorder window: window size, field widths,
// command and status codes, and the record passed from front to back.
// Depends on nothing; every other file of the block but srw_ram uses it.
package srw_pkg;

	// Number of ring slots; must be a power of two.
	localparam int WINDOW = 16;
	localparam int SLOT_W = $clog2(WINDOW);
	// Wide enough to hold WINDOW itself (slot index "absent", full occupancy).
	localparam int IDX_W = SLOT_W + 1;

	localparam int SEQ_W = 64;
	localparam int PAYLOAD_W = 64;
	localparam int STREAM_W = 32;
	localparam int RAM_W = PAYLOAD_W + STREAM_W;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_POP = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_STORED = 4'd0,
		ST_TOO_OLD = 4'd1,
		ST_TOO_FAR = 4'd2,
		ST_DUPLICATE = 4'd3,
		ST_DELIVERED = 4'd4,
		ST_NONE_READY = 4'd5,
		ST_CLEARED = 4'd6,
		ST_FOUND = 4'd7,
		ST_ABSENT = 4'd8
	} status_t;

	// One classified command, as the back part carries it out.
	typedef struct packed {
		logic deliver;
		logic store;
		logic [SLOT_W-1:0] slot;
		status_t status;
		logic [PAYLOAD_W-1:0] payload;
		logic [STREAM_W-1:0] stream;
		logic [SEQ_W-1:0] dseq;
		logic [IDX_W-1:0] slot_index;
		logic ready;
		logic [IDX_W-1:0] occupancy;
	} op_t;

endpackage

// ===== hw/rtl/srw_if.sv =====
// Handshake interfaces for the command and result channels.
// Depends on srw_pkg for the field widths.
interface srw_req_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [srw_pkg::SEQ_W-1:0] seq_num;
	logic [srw_pkg::PAYLOAD_W-1:0] payload_in;
	logic [srw_pkg::STREAM_W-1:0] stream_in;

	modport source (output valid, cmd, seq_num, payload_in, stream_in, input ready);
	modport sink (input valid, cmd, seq_num, payload_in, stream_in, output ready);
endinterface

interface srw_rsp_if;
	logic valid;
	logic ready;
	logic [3:0] status;
	logic [srw_pkg::PAYLOAD_W-1:0] payload_out;
	logic [srw_pkg::STREAM_W-1:0] stream_out;
	logic [srw_pkg::SEQ_W-1:0] delivered_seq;
	logic [srw_pkg::IDX_W-1:0] slot_index;
	logic ready_flag;
	logic [srw_pkg::IDX_W-1:0] occupancy;

	modport source (output valid, status, payload_out, stream_out, delivered_seq, slot_index,
		ready_flag, occupancy, input ready);
	modport sink (input valid, status, payload_out, stream_out, delivered_seq, slot_index,
		ready_flag, occupancy, output ready);
endinterface

// ===== hw/rtl/sequence_reorder_window.sv =====
// Top level of the sequence reorder window: front, queue and back part.
// Depends on srw_pkg, srw_if, srw_front, srw_queue, srw_back and srw_ram.
//
//   Channel  Direction  Carries
//   req      in         cmd, seq_num, payload_in, stream_in
//   rsp      out        status, payload_out, stream_out, delivered_seq,
//                       slot_index, ready_flag, occupancy
//
// One command transfer per cycle is sustained while rsp takes results. A command is
// classified into the queue, then its record passes with one slot memory access
// into the output register. The front holds all window control state in
// flip-flops, so reset alone empties the window; no clearing pass is needed.
// When rsp stalls, the queue fills and req.ready falls once it is full.
module sequence_reorder_window (
	input logic clk,
	input logic arst_n,
	srw_req_if.sink req,
	srw_rsp_if.source rsp
);

	srw_pkg::op_t push_data;
	srw_pkg::op_t pop_data;
	logic push;
	logic pop;
	logic full;
	logic empty;

	srw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.full(full),
		.push(push),
		.entry(push_data)
	);

	srw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	srw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.entry(pop_data),
		.empty(empty),
		.pop(pop),
		.rsp(rsp)
	);

endmodule

// ===== hw/rtl/srw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module srw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/srw_front.sv =====
// Front part: accepts commands, classifies them against the window state
// (expected sequence, head slot, valid bits, occupancy) and queues a record.
// Depends on srw_pkg and srw_if.
module srw_front (
	input logic clk,
	input logic arst_n,
	srw_req_if.sink req,
	input logic full,
	output logic push,
	output srw_pkg::op_t entry
);

	localparam logic [srw_pkg::IDX_W-1:0] WINDOW_IDX = srw_pkg::IDX_W'(srw_pkg::WINDOW);

	logic [srw_pkg::SEQ_W-1:0] expected_q, expected_d;
	logic [srw_pkg::SLOT_W-1:0] head_q, head_d;
	logic [srw_pkg::IDX_W-1:0] count_q, count_d;
	logic [srw_pkg::WINDOW-1:0] valid_q, valid_d;

	logic [srw_pkg::SEQ_W-1:0] offset;
	logic too_old;
	logic too_far;
	logic [srw_pkg::SLOT_W-1:0] pos;
	logic accept;

	assign req.ready = !full;
	assign accept = req.valid && !full;
	assign push = accept;

	// Window position of the incoming sequence number.
	assign offset = req.seq_num - expected_q;
	assign too_old = req.seq_num < expected_q;
	assign too_far = |offset[srw_pkg::SEQ_W-1:srw_pkg::SLOT_W];
	assign pos = head_q + offset[srw_pkg::SLOT_W-1:0];

	// Classify the command and work out the next window state. A valid slot always
	// holds the sequence that its place in the window implies, so the valid bit alone
	// decides duplicates, lookups and head readiness.
	always_comb begin
		expected_d = expected_q;
		head_d = head_q;
		count_d = count_q;
		valid_d = valid_q;
		entry = '0;
		entry.slot_index = WINDOW_IDX;
		entry.payload = req.payload_in;
		entry.stream = req.stream_in;
		entry.status = srw_pkg::ST_STORED;
		unique case (srw_pkg::cmd_t'(req.cmd))
			srw_pkg::CMD_ADD: begin
				entry.slot = pos;
				if (too_old) begin
					entry.status = srw_pkg::ST_TOO_OLD;
				end else if (too_far) begin
					entry.status = srw_pkg::ST_TOO_FAR;
				end else if (valid_q[pos]) begin
					entry.status = srw_pkg::ST_DUPLICATE;
				end else begin
					entry.status = srw_pkg::ST_STORED;
					entry.store = 1'b1;
					valid_d[pos] = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			srw_pkg::CMD_POP: begin
				entry.slot = head_q;
				if (valid_q[head_q]) begin
					entry.status = srw_pkg::ST_DELIVERED;
					entry.deliver = 1'b1;
					entry.dseq = expected_q;
					valid_d[head_q] = 1'b0;
					expected_d = expected_q + 1'b1;
					head_d = head_q + 1'b1;
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
				end else begin
					entry.status = srw_pkg::ST_NONE_READY;
				end
			end
			srw_pkg::CMD_CLEAR: begin
				entry.status = srw_pkg::ST_CLEARED;
				valid_d = '0;
				expected_d = '0;
				head_d = '0;
				count_d = '0;
			end
			srw_pkg::CMD_LOOKUP: begin
				if (!too_old && !too_far && valid_q[pos]) begin
					entry.status = srw_pkg::ST_FOUND;
					entry.slot_index = {1'b0, pos};
				end else begin
					entry.status = srw_pkg::ST_ABSENT;
				end
			end
			default: begin
				entry.status = srw_pkg::ST_ABSENT;
			end
		endcase
		entry.ready = valid_d[head_d];
		entry.occupancy = count_d;
	end

	// Window state advances on every accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			head_q <= '0;
			count_q <= '0;
			valid_q <= '0;
		end else if (accept) begin
			expected_q <= expected_d;
			head_q <= head_d;
			count_q <= count_d;
			valid_q <= valid_d;
		end
	end

endmodule

// ===== hw/rtl/srw_queue.sv =====
// Short queue of classified records between the front and the back part.
// Depends on srw_pkg.
module srw_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input srw_pkg::op_t push_data,
	output logic full,
	input logic pop,
	output srw_pkg::op_t pop_data,
	output logic empty
);

	localparam int PTR_W = (srw_pkg::QUEUE_DEPTH > 1) ? $clog2(srw_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(srw_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(srw_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(srw_pkg::QUEUE_DEPTH - 1);

	srw_pkg::op_t entry_q [srw_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == DEPTH_CNT;
	assign empty = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/srw_back.sv =====
// Back part: carries out queued records against the slot memory (store on add,
// read on delivery) and holds the result in an output register.
// Depends on srw_pkg, srw_if and srw_ram.
module srw_back (
	input logic clk,
	input logic arst_n,
	input srw_pkg::op_t entry,
	input logic empty,
	output logic pop,
	srw_rsp_if.source rsp
);

	srw_pkg::op_t op_s1;
	logic valid_q;
	logic take;
	logic [srw_pkg::RAM_W-1:0] rdata;

	// Take the next record when the output register is free or being drained.
	assign take = !empty && (!valid_q || rsp.ready);
	assign pop = take;

	// Payload and stream id of every slot; read at the head on delivery.
	srw_ram #(
		.WIDTH(srw_pkg::RAM_W),
		.DEPTH(srw_pkg::WINDOW)
	) u_slot_ram (
		.clk(clk),
		.we(take && entry.store),
		.waddr(entry.slot),
		.wdata({entry.stream, entry.payload}),
		.re(take && entry.deliver),
		.raddr(entry.slot),
		.rdata(rdata)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result fields; memory data shows only for a delivery.
	assign rsp.valid = valid_q;
	assign rsp.status = op_s1.status;
	assign rsp.payload_out = op_s1.deliver ? rdata[srw_pkg::PAYLOAD_W-1:0] : '0;
	assign rsp.stream_out = op_s1.deliver ? rdata[srw_pkg::RAM_W-1:srw_pkg::PAYLOAD_W] : '0;
	assign rsp.delivered_seq = op_s1.dseq;
	assign rsp.slot_index = op_s1.slot_index;
	assign rsp.ready_flag = op_s1.ready;
	assign rsp.occupancy = op_s1.occupancy;

endmodule

// ===== tb/tb_sequence_reorder_window.sv =====
// Self-checking testbench for the sequence reorder window: a directed table and random
// commands go in on req; every rsp transfer is checked against a bench model or typed row.
// Depends on srw_pkg, srw_if and the sequence_reorder_window RTL.
`timescale 1ns / 1ps

module tb_sequence_reorder_window;
	import srw_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1825;

	typedef struct packed {
		status_t status;
		logic [PAYLOAD_W-1:0] payload;
		logic [STREAM_W-1:0] stream;
		logic [SEQ_W-1:0] dseq;
		logic [IDX_W-1:0] slot;
		logic ready;
		logic [IDX_W-1:0] occ;
	} window_result_t;

	typedef struct packed {
		cmd_t op;
		logic [SEQ_W-1:0] seq;
		logic [PAYLOAD_W-1:0] payload;
		logic [STREAM_W-1:0] stream;
		logic typed;
		window_result_t want;
	} command_row_t;

	logic clk;
	logic arst_n;

	srw_req_if req_ch();
	srw_rsp_if rsp_ch();

	sequence_reorder_window u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Window model state.
	logic [SEQ_W-1:0] win_exp;
	logic [SLOT_W-1:0] win_head;
	logic [IDX_W-1:0] win_held;
	logic win_valid [WINDOW];
	logic [SEQ_W-1:0] win_seq [WINDOW];
	logic [PAYLOAD_W-1:0] win_payload [WINDOW];
	logic [STREAM_W-1:0] win_stream [WINDOW];

	window_result_t pending_results[$];
	command_row_t directed_rows[$];
	int err_count;
	int idle_cycles;
	bit send_burst;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic head_holds_expected();
		return win_valid[win_head] && (win_seq[win_head] == win_exp);
	endfunction

	// Applies one command to the window model and returns the result it causes.
	function automatic window_result_t predict_window_result(cmd_t op, logic [SEQ_W-1:0] seq,
		logic [PAYLOAD_W-1:0] pay, logic [STREAM_W-1:0] strm);
		window_result_t res;
		logic [SEQ_W-1:0] offset;
		logic [SLOT_W-1:0] pos;
		logic in_window;
		res = '0;
		res.slot = IDX_W'(WINDOW);
		offset = seq - win_exp;
		in_window = (seq >= win_exp) && (offset < SEQ_W'(WINDOW));
		pos = win_head + offset[SLOT_W-1:0];
		case (op)
			CMD_ADD: begin
				if (seq < win_exp) begin
					res.status = ST_TOO_OLD;
				end else if (!in_window) begin
					res.status = ST_TOO_FAR;
				end else if (win_valid[pos] && win_seq[pos] == seq) begin
					res.status = ST_DUPLICATE;
				end else begin
					if (!win_valid[pos])
						win_held = win_held + 1'b1;
					win_valid[pos] = 1'b1;
					win_seq[pos] = seq;
					win_payload[pos] = pay;
					win_stream[pos] = strm;
					res.status = ST_STORED;
				end
			end
			CMD_POP: begin
				if (head_holds_expected()) begin
					res.payload = win_payload[win_head];
					res.stream = win_stream[win_head];
					res.dseq = win_exp;
					win_valid[win_head] = 1'b0;
					win_seq[win_head] = '0;
					win_stream[win_head] = '0;
					win_exp = win_exp + 1'b1;
					win_head = win_head + 1'b1;
					if (win_held != '0)
						win_held = win_held - 1'b1;
					res.status = ST_DELIVERED;
				end else begin
					res.status = ST_NONE_READY;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < WINDOW; i++) begin
					win_valid[i] = 1'b0;
					win_seq[i] = '0;
				end
				win_exp = '0;
				win_head = '0;
				win_held = '0;
				res.status = ST_CLEARED;
			end
			default: begin
				if (in_window && win_valid[pos] && win_seq[pos] == seq) begin
					res.status = ST_FOUND;
					res.slot = IDX_W'(pos);
				end else begin
					res.status = ST_ABSENT;
				end
			end
		endcase
		res.ready = head_holds_expected();
		res.occ = win_held;
		return res;
	endfunction

	// Directed rows; a typed row carries a result with zero data fields and no slot.
	task automatic add_row(cmd_t op, logic [SEQ_W-1:0] seq, logic [PAYLOAD_W-1:0] pay,
		logic [STREAM_W-1:0] strm, logic typed, status_t st);
		command_row_t r;
		r.op = op;
		r.seq = seq;
		r.payload = pay;
		r.stream = strm;
		r.typed = typed;
		r.want = '0;
		r.want.status = st;
		r.want.slot = IDX_W'(WINDOW);
		directed_rows.push_back(r);
	endtask

	// Offers one command after a random gap and records its expected result on transfer.
	task automatic send_row(command_row_t r);
		int gap;
		window_result_t predicted;
		gap = send_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= r.op;
		req_ch.seq_num <= r.seq;
		req_ch.payload_in <= r.payload;
		req_ch.stream_in <= r.stream;
		do @(posedge clk); while (!req_ch.ready);
		predicted = predict_window_result(r.op, r.seq, r.payload, r.stream);
		pending_results.push_back(r.typed ? r.want : predicted);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// Result checker: each rsp transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		window_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no command outstanding: status %0d",
					rsp_ch.status);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 64'(want.status), 64'(rsp_ch.status));
				check_field("payload_out", want.payload, rsp_ch.payload_out);
				check_field("stream_out", 64'(want.stream), 64'(rsp_ch.stream_out));
				check_field("delivered_seq", want.dseq, rsp_ch.delivered_seq);
				check_field("slot_index", 64'(want.slot), 64'(rsp_ch.slot_index));
				check_field("ready_flag", 64'(want.ready), 64'(rsp_ch.ready_flag));
				check_field("occupancy", 64'(want.occ), 64'(rsp_ch.occupancy));
			end
		end
	end

	// Watchdog on cycles in which neither channel completes a transfer.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[sequence_reorder_window] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result receiver: random stalls, stall-free stretches and two long hold-offs.
	initial begin
		int wait_cycles;
		int received;
		bit recv_burst;
		received = 0;
		recv_burst = 1'b0;
		rsp_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (received % 50 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
			wait_cycles = recv_burst ? 0 : $urandom_range(0, 9);
			if (received == 500 || received == 1400)
				wait_cycles = HOLD_CYCLES;
			if (wait_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			received++;
		end
	end

	// Reset, directed table, random commands, drain and verdict.
	initial begin
		command_row_t r;
		int pick;
		err_count = 0;
		idle_cycles = 0;
		send_burst = 1'b0;
		win_exp = '0;
		win_head = '0;
		win_held = '0;
		for (int i = 0; i < WINDOW; i++) begin
			win_valid[i] = 1'b0;
			win_seq[i] = '0;
			win_payload[i] = '0;
			win_stream[i] = '0;
		end
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_ADD;
		req_ch.seq_num <= '0;
		req_ch.payload_in <= '0;
		req_ch.stream_in <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty window, field extremes, wrap of the slot ring, duplicates and stale adds.
		add_row(CMD_POP, '0, '0, '0, 1'b1, ST_NONE_READY);
		add_row(CMD_LOOKUP, '0, '0, '0, 1'b1, ST_ABSENT);
		add_row(CMD_ADD, '1, '1, '1, 1'b1, ST_TOO_FAR);
		add_row(CMD_ADD, 64'd16, '0, '0, 1'b1, ST_TOO_FAR);
		add_row(CMD_ADD, 64'd15, '0, '0, 1'b0, ST_STORED);
		add_row(CMD_ADD, '0, '1, '1, 1'b0, ST_STORED);
		add_row(CMD_ADD, '0, {32{2'b01}}, '0, 1'b0, ST_DUPLICATE);
		add_row(CMD_LOOKUP, 64'd15, '0, '0, 1'b0, ST_FOUND);
		add_row(CMD_LOOKUP, '0, '0, '0, 1'b0, ST_FOUND);
		add_row(CMD_LOOKUP, 64'd16, '0, '0, 1'b0, ST_ABSENT);
		add_row(CMD_LOOKUP, '1, '0, '0, 1'b0, ST_ABSENT);
		add_row(CMD_POP, '0, '0, '0, 1'b0, ST_DELIVERED);
		add_row(CMD_ADD, '0, '1, '1, 1'b0, ST_TOO_OLD);
		add_row(CMD_LOOKUP, '0, '0, '0, 1'b0, ST_ABSENT);
		add_row(CMD_POP, '0, '0, '0, 1'b0, ST_NONE_READY);
		add_row(CMD_ADD, 64'd16, {32{2'b10}}, {16{2'b01}}, 1'b0, ST_STORED);
		add_row(CMD_LOOKUP, 64'd16, '0, '0, 1'b0, ST_FOUND);
		add_row(CMD_ADD, 64'd1, {32{2'b01}}, {16{2'b10}}, 1'b0, ST_STORED);
		add_row(CMD_POP, '0, '0, '0, 1'b0, ST_DELIVERED);
		add_row(CMD_POP, '0, '0, '0, 1'b0, ST_NONE_READY);
		add_row(CMD_CLEAR, '1, '1, '1, 1'b1, ST_CLEARED);
		add_row(CMD_LOOKUP, 64'd16, '0, '0, 1'b1, ST_ABSENT);
		add_row(CMD_ADD, '0, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, ST_STORED);
		add_row(CMD_POP, '0, '0, '0, 1'b0, ST_DELIVERED);
		add_row(CMD_ADD, '0, '0, '0, 1'b0, ST_TOO_OLD);
		foreach (directed_rows[i])
			send_row(directed_rows[i]);

		// Random commands, mostly adds near the expected sequence and in-order pops.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				send_burst = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			r = '0;
			r.payload = {$urandom, $urandom};
			r.stream = $urandom;
			r.seq = {$urandom, $urandom};
			if (pick < 45) begin
				r.op = CMD_ADD;
				r.seq = win_exp + $urandom_range(0, WINDOW - 1);
			end else if (pick < 50) begin
				r.op = CMD_ADD;
				r.seq = win_exp + $urandom_range(WINDOW, WINDOW + 3);
			end else if (pick < 53) begin
				r.op = CMD_ADD;
				r.seq = win_exp - $urandom_range(1, 4);
			end else if (pick < 56) begin
				r.op = CMD_ADD;
			end else if (pick < 85) begin
				r.op = CMD_POP;
			end else if (pick < 95) begin
				r.op = CMD_LOOKUP;
				r.seq = win_exp + $urandom_range(0, WINDOW + 1);
			end else if (pick < 98) begin
				r.op = CMD_LOOKUP;
			end else begin
				r.op = CMD_CLEAR;
			end
			send_row(r);
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("[sequence_reorder_window] OK");
		else
			$display("[sequence_reorder_window] ERROR");
		$finish;
	end

endmodule
